FILE: rtl/periodic_soft_timer_macros.svh
// Assertion macros for the periodic soft timer RTL.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef PERIODIC_SOFT_TIMER_MACROS_SVH
`define PERIODIC_SOFT_TIMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pst_pkg.sv
// Shared types and constants for the periodic soft timer.
// No dependencies; imported by all RTL modules of the block.
package pst_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned TurnW  = 8;
  localparam int unsigned CfgIdxW = 2;

  // Result word: fired, active_now, elapsed_ms, overdue, then zero pad.
  localparam int unsigned OutUsedW = 1 + 1 + TimeW + 1;
  localparam int unsigned OutW     = ((OutUsedW + 7) / 8) * 8;

  // Remainder unit: two quotient bits per cycle.
  localparam int unsigned RemSteps = 2;
  localparam int unsigned RemIters = TimeW / RemSteps;
  localparam int unsigned RemCntW  = $clog2(RemIters);

  typedef enum logic [ReqW-1:0] {
    REQ_POLL       = 3'd0,
    REQ_ACTIVATE   = 3'd1,
    REQ_DEACTIVATE = 3'd2,
    REQ_PAUSE      = 3'd3,
    REQ_RESUME     = 3'd4,
    REQ_RESTART    = 3'd5
  } req_e;

  typedef enum logic [ModeW-1:0] {
    MODE_REPEAT  = 2'd0,
    MODE_ONESHOT = 2'd1,
    MODE_TURN    = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE       = 2'd0,
    CFG_PERIOD     = 2'd1,
    CFG_TURN_LIMIT = 2'd2,
    CFG_START_ACT  = 2'd3
  } cfg_idx_e;

  localparam logic [ModeW-1:0] ModeRst       = MODE_REPEAT;
  localparam logic [TimeW-1:0] PeriodRst     = 32'd1000;
  localparam logic [TurnW-1:0] TurnLimitRst  = 8'd1;
  localparam logic             StartActRst   = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic cap_in;     // latch the request payload
    logic eval;       // decode request, update state
    logic start_div;  // launch catch-up remainder
    logic apply_div;  // write caught-up start time
    logic load_out;   // fill the output register
  } pst_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
  } pst_stat_t;

endpackage

FILE: rtl/pst_rem.sv
// Iterative remainder unit, RemSteps bits per cycle (restoring).
// Depends on pst_pkg.
module pst_rem import pst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] dividend_i,
  input  logic [TimeW-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [TimeW-1:0] rem_o
);

  logic [TimeW-1:0]   rem_q, sh_q, div_q, rem_d;
  logic [RemCntW-1:0] cnt_q;
  logic               busy_q, done_q;

  always_comb begin
    logic [TimeW:0]   t;
    logic [TimeW-1:0] r;
    r = rem_q;
    t = '0;
    for (int i = 0; i < RemSteps; i++) begin
      t = {r, sh_q[TimeW-1-i]};
      if (t >= {1'b0, div_q}) begin
        r = TimeW'(t - {1'b0, div_q});
      end else begin
        r = t[TimeW-1:0];
      end
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == RemCntW'(RemIters - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sh_q  <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << RemSteps;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/pst_dp.sv
// Timer datapath: config registers, timer state, catch-up math, output register.
// Depends on pst_pkg and pst_rem.
module pst_dp import pst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_wdata_i,
  input  logic [ReqW-1:0]    req_i,
  input  logic [TimeW-1:0]   now_i,
  input  pst_cmd_t           cmd_i,
  output pst_stat_t          stat_o,
  output logic [OutW-1:0]    out_data_o
);

  logic [ModeW-1:0] mode_q;
  logic [TimeW-1:0] period_q;
  logic [TurnW-1:0] tlimit_q;

  logic [TimeW-1:0] start_q, paused_q;
  logic             running_q;
  logic [TurnW-1:0] tc_q;

  logic [ReqW-1:0]  req_q;
  logic [TimeW-1:0] now_q;
  logic             fired_q, overdue_q;
  logic [OutW-1:0]  out_q;

  logic [TimeW-1:0] p_eff, elapsed0, lim, gap, adj, caught, rem;
  logic [TimeW:0]   sum;
  logic [TurnW-1:0] tc_inc;
  logic             fire, need_div, div_busy, div_done;

  // Zero period behaves as one millisecond.
  assign p_eff    = (period_q == '0) ? TimeW'(1) : period_q;
  assign elapsed0 = now_q - start_q;
  assign lim      = now_q - p_eff;
  assign sum      = {1'b0, start_q} + {1'b0, p_eff};
  assign fire     = (req_q == REQ_POLL) && running_q && (elapsed0 >= p_eff);
  // One step is enough unless start + P is still behind now - P.
  assign need_div = fire && (sum < {1'b0, lim});
  assign gap      = lim - start_q;
  // Round up to the next period boundary at or past lim.
  assign adj      = (rem == '0) ? '0 : p_eff - rem;
  assign caught   = lim + adj;
  assign tc_inc   = tc_q + 1'b1;

  pst_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (gap),
    .divisor_i  (p_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  // start_active only selects the running value at reset; its reset value
  // is the only one that reset ever sees, so it needs no storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeRst;
      period_q <= PeriodRst;
      tlimit_q <= TurnLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:       mode_q   <= cfg_wdata_i[ModeW-1:0];
        CFG_PERIOD:     period_q <= cfg_wdata_i;
        CFG_TURN_LIMIT: tlimit_q <= cfg_wdata_i[TurnW-1:0];
        CFG_START_ACT:  ;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      paused_q  <= '0;
      running_q <= StartActRst;
      tc_q      <= '0;
    end else if (cmd_i.eval) begin
      unique case (req_q)
        REQ_POLL: begin
          if (fire) begin
            if (!need_div) begin
              start_q <= sum[TimeW-1:0];
            end
            case (mode_q)
              MODE_ONESHOT: running_q <= 1'b0;
              MODE_TURN: begin
                if (tc_inc >= tlimit_q) begin
                  tc_q      <= '0;
                  running_q <= 1'b0;
                end else begin
                  tc_q <= tc_inc;
                end
              end
              default: ;
            endcase
          end
        end
        REQ_ACTIVATE: begin
          start_q   <= now_q;
          running_q <= 1'b1;
        end
        REQ_DEACTIVATE: begin
          paused_q  <= elapsed0;
          start_q   <= '0;
          running_q <= 1'b0;
        end
        REQ_PAUSE: begin
          paused_q  <= elapsed0;
          running_q <= 1'b0;
        end
        REQ_RESUME: begin
          start_q   <= now_q - paused_q;
          running_q <= 1'b1;
        end
        REQ_RESTART: start_q <= now_q;
        default: ;
      endcase
    end else if (cmd_i.apply_div) begin
      start_q <= caught;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      req_q <= req_i;
      now_q <= now_i;
    end
    if (cmd_i.eval) begin
      fired_q   <= fire;
      overdue_q <= running_q && (elapsed0 > period_q);
    end
    if (cmd_i.load_out) begin
      out_q <= {(OutW - OutUsedW)'(0), overdue_q, now_q - start_q, running_q, fired_q};
    end
  end

  assign stat_o.need_div = need_div;
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;
  assign out_data_o      = out_q;

endmodule

FILE: rtl/pst_ctrl.sv
// Request sequencer for the periodic soft timer: handshakes and datapath commands.
// Depends on pst_pkg.
module pst_ctrl import pst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  input  pst_stat_t stat_i,
  output pst_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   m_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.cap_in = s_valid_i;
      ST_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.start_div = stat_i.need_div;
      end
      ST_DIV:  cmd_o.apply_div = stat_i.div_done;
      ST_OUT:  cmd_o.load_out  = !m_valid_q || m_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (s_valid_i) state_q <= ST_EVAL;
        ST_EVAL: state_q <= stat_i.need_div ? ST_DIV : ST_OUT;
        ST_DIV:  if (stat_i.div_done) state_q <= ST_OUT;
        ST_OUT:  if (cmd_o.load_out) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

FILE: rtl/periodic_soft_timer.sv
// Periodic soft timer, top level: handshake sequencer plus timer datapath.
// Depends on pst_pkg, pst_ctrl, pst_dp, pst_rem and periodic_soft_timer_macros.svh.
//
// Usage: each request on the slave stream carries a kind in tuser (poll,
// activate, deactivate, pause, resume, restart) and the free-running
// millisecond time in tdata. Every request yields exactly one result on the
// master stream: fired, active_now, elapsed_ms and overdue.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 mode,
// 1 period_ms, 2 turn_limit; 3 start_active is taken but not stored).
// The user must write only while no request is in flight; the block
// itself does not enforce this. Timing: one request at a time. A plain
// request passes the EVAL and OUT states before it lands in the output
// register; the next request is accepted only back in IDLE. A poll that
// fires more than one period late also runs the catch-up remainder unit
// in the DIV state, 2 bits per cycle, before its result is loaded.
// Stall: the result sits in the output register until taken; the next
// request is still accepted meanwhile, and its result waits in the
// datapath until the output register frees up.
// Reset: asynchronous, active low. The timer comes up running with start
// time 0, period 1000, repeat mode and turn limit 1.
`include "periodic_soft_timer_macros.svh"

module periodic_soft_timer import pst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TimeW-1:0]   s_axis_tdata,   // [31:0] now_ms
  input  logic [ReqW-1:0]    s_axis_tuser,   // [2:0] req_type
  // Result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OutW-1:0]    m_axis_tdata,   // [0] fired, [1] active_now,
                                             // [33:2] elapsed_ms, [34] overdue
  // Config write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [TimeW-1:0]   cfg_wdata_i
);

  pst_cmd_t  cmd;
  pst_stat_t stat;

  pst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (s_axis_tuser),
    .now_i       (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );

  // Only one request in flight: no accept right after an accept.
  `PST_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while one is in flight")

  // The catch-up unit only runs while the input side is closed.
  `PST_ASSERT_NOW(a_div_blocks_input, stat.div_busy, !s_axis_tready, "input open during catch-up")

  // Loading the output register always presents a result.
  `PST_ASSERT_NEXT(a_load_shows_result, cmd.load_out, m_axis_tvalid, "result loaded but not presented")

endmodule

FILE: tb/sv/periodic_soft_timer_tb.sv
// Self-checking testbench for periodic_soft_timer: stream-driven requests,
// a cycle-free timer predictor and an in-order result checker.
// Depends on pst_pkg and the periodic_soft_timer RTL only.
`timescale 1ns / 100ps

module periodic_soft_timer_tb;
  import pst_pkg::*;

  // Request codes the block must ignore (still one result each).
  localparam logic [ReqW-1:0]  REQ_BAD_LO   = 3'd6;
  localparam logic [ReqW-1:0]  REQ_BAD_HI   = 3'd7;
  // Mode encoding with no meaning of its own; behaves as repeat.
  localparam logic [ModeW-1:0] MODE_UNUSED  = 2'd3;
  localparam int unsigned      PHASE_ITEMS  = 45;
  localparam int unsigned      TAIL_CYCLES  = 40;

  // One result as the timer reports it.
  typedef struct {
    logic             fired;
    logic             active;
    logic [TimeW-1:0] elapsed;
    logic             overdue;
  } timer_result_t;

  // Tracks timer state per accepted request and checks results in order.
  class timer_tracker;
    logic [ModeW-1:0] mode;
    logic [TimeW-1:0] period;
    logic [TurnW-1:0] turn_limit;
    logic             start_act;
    logic [TimeW-1:0] start_time;
    logic             running;
    logic [TurnW-1:0] turn_count;
    logic [TimeW-1:0] held_elapsed;
    timer_result_t    pending_results[$];
    int unsigned      errors;

    function new();
      mode         = ModeRst;
      period       = PeriodRst;
      turn_limit   = TurnLimitRst;
      start_act    = StartActRst;
      start_time   = '0;
      running      = StartActRst;
      turn_count   = '0;
      held_elapsed = '0;
      errors       = 0;
    endfunction

    // Config write; start_act only matters at reset, which never recurs.
    function void set_reg(cfg_idx_e idx, logic [TimeW-1:0] val);
      case (idx)
        CFG_MODE:       mode       = val[ModeW-1:0];
        CFG_PERIOD:     period     = val;
        CFG_TURN_LIMIT: turn_limit = val[TurnW-1:0];
        CFG_START_ACT:  start_act  = val[0];
        default: ;
      endcase
    endfunction

    // New start after firing: smallest k >= 1 such that start + k*p is no
    // longer behind now - p, taken mod 2^32 (covers the early stop on wrap).
    function logic [TimeW-1:0] advance_start(logic [TimeW-1:0] base,
                                             logic [TimeW-1:0] now,
                                             logic [TimeW-1:0] eff_p);
      logic [TimeW-1:0] lim;
      logic [63:0]      steps;
      logic [63:0]      gap;
      logic [63:0]      sum;
      lim   = now - eff_p;
      steps = 64'd1;
      if ({32'd0, base} + {32'd0, eff_p} < {32'd0, lim}) begin
        gap   = {32'd0, lim} - {32'd0, base};
        steps = (gap + {32'd0, eff_p} - 64'd1) / {32'd0, eff_p};
        if (steps == 64'd0) steps = 64'd1;
      end
      sum = {32'd0, base} + steps * {32'd0, eff_p};
      return sum[TimeW-1:0];
    endfunction

    function void note_request(logic [ReqW-1:0] req, logic [TimeW-1:0] now);
      timer_result_t    want;
      logic [TimeW-1:0] eff_p;
      logic [TimeW-1:0] so_far;
      eff_p        = (period == '0) ? 32'd1 : period;
      so_far       = now - start_time;
      want.fired   = 1'b0;
      // overdue looks at the raw period, before anything moves
      want.overdue = running && (so_far > period);
      case (req)
        REQ_POLL: begin
          if (running && so_far >= eff_p) begin
            start_time = advance_start(start_time, now, eff_p);
            want.fired = 1'b1;
            if (mode == MODE_ONESHOT) begin
              running = 1'b0;
            end else if (mode == MODE_TURN) begin
              turn_count = turn_count + 8'd1;
              if (turn_count >= turn_limit) begin
                turn_count = '0;
                running    = 1'b0;
              end
            end
          end
        end
        REQ_ACTIVATE: begin
          start_time = now;
          running    = 1'b1;
        end
        REQ_DEACTIVATE: begin
          held_elapsed = now - start_time;
          start_time   = '0;
          running      = 1'b0;
        end
        REQ_PAUSE: begin
          held_elapsed = now - start_time;
          running      = 1'b0;
        end
        REQ_RESUME: begin
          start_time = now - held_elapsed;
          running    = 1'b1;
        end
        REQ_RESTART: start_time = now;
        default: ;
      endcase
      want.active  = running;
      want.elapsed = now - start_time;
      pending_results.push_back(want);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(logic [OutW-1:0] word);
      timer_result_t want;
      timer_result_t seen;
      seen.fired   = word[0];
      seen.active  = word[1];
      seen.elapsed = word[33:2];
      seen.overdue = word[34];
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (seen.fired !== want.fired)
        report_mismatch($sformatf("fired %b, want %b", seen.fired, want.fired));
      if (seen.active !== want.active)
        report_mismatch($sformatf("active_now %b, want %b", seen.active, want.active));
      if (seen.elapsed !== want.elapsed)
        report_mismatch($sformatf("elapsed_ms %h, want %h", seen.elapsed, want.elapsed));
      if (seen.overdue !== want.overdue)
        report_mismatch($sformatf("overdue %b, want %b", seen.overdue, want.overdue));
    endtask
  endclass

  // Every block input starts at a known value.
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TimeW-1:0]   s_axis_tdata  = '0;
  logic [ReqW-1:0]    s_axis_tuser  = REQ_POLL;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutW-1:0]    m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = CFG_MODE;
  logic [TimeW-1:0]   cfg_wdata_i   = '0;

  timer_tracker tracker = new();

  // Percent chance per cycle that the request side idles or the result
  // side stalls; the main sequence switches these between regimes.
  int unsigned src_idle_pct   = 11;
  int unsigned sink_stall_pct = 73;

  req_e other_ops[5] = '{REQ_ACTIVATE, REQ_DEACTIVATE, REQ_PAUSE,
                         REQ_RESUME, REQ_RESTART};

  periodic_soft_timer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [31:0] now_ms
    .s_axis_tuser  (s_axis_tuser),   // [2:0] req_type
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] fired, [1] active_now,
                                     // [33:2] elapsed_ms, [34] overdue
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Result side: values read right after the edge are the pre-edge ones,
  // so a result counts when tvalid and tready were both high at this edge.
  // tready is redrawn every cycle from the current stall rate.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Hard stop well past the slowest legal run (439 requests, plus
  // catch-up and config writes).
  initial begin
    #5_000_000;
    $display("periodic_soft_timer_tb NOT OK");
    $finish;
  end

  // Present one request, with random idle cycles ahead of it, and hold it
  // until accepted. Entered and left right after a rising edge, so tvalid
  // gets exactly one assignment per step and stays high between
  // back-to-back requests.
  task automatic send_request(logic [ReqW-1:0] req, logic [TimeW-1:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(req, now);
  endtask

  // Stop sending and wait until every outstanding result has been taken.
  // Each request yields a result, so the block is idle afterwards.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write all four registers on consecutive edges; only called when idle.
  task automatic write_regs(logic [ModeW-1:0] mode_v, logic [TimeW-1:0] per_v,
                            logic [TurnW-1:0] lim_v, logic act_v);
    logic [TimeW-1:0] vals[4];
    vals = '{{30'd0, mode_v}, per_v, {24'd0, lim_v}, {31'd0, act_v}};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      tracker.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Next request time: mostly forward steps sized against the period so
  // polls land before, on and just after the boundary, or several periods
  // late (catch-up); now and then a random jump or an absolute time.
  function automatic logic [TimeW-1:0] next_time(logic [TimeW-1:0] cur);
    logic [63:0] eff_p;
    logic [63:0] delta;
    eff_p = (tracker.period == '0) ? 64'd1 : {32'd0, tracker.period};
    case ($urandom_range(9))
      0, 1, 2: delta = {32'd0, $urandom} % (eff_p + 64'd1);
      3, 4, 5: delta = eff_p - 64'd2 + $urandom_range(4);
      6, 7:    delta = eff_p * $urandom_range(6, 2) + ({32'd0, $urandom} % eff_p);
      8:       delta = {32'd0, $urandom};
      default: return $urandom;
    endcase
    return cur + delta[TimeW-1:0];
  endfunction

  // Directed opener at reset settings (repeat, period 1000, running, start
  // 0): boundary polls, a late poll with catch-up, the ignored codes, poll
  // while stopped, every request kind, wrap of the time value and field
  // extremes.
  task automatic run_directed();
    logic [ReqW-1:0]  dir_req[25];
    logic [TimeW-1:0] dir_now[25];
    dir_req = '{REQ_POLL, REQ_POLL, REQ_POLL, REQ_POLL, REQ_POLL,
                REQ_BAD_LO, REQ_BAD_HI, REQ_PAUSE, REQ_POLL, REQ_RESUME,
                REQ_RESTART, REQ_POLL, REQ_DEACTIVATE, REQ_POLL, REQ_ACTIVATE,
                REQ_POLL, REQ_POLL, REQ_POLL, REQ_POLL, REQ_ACTIVATE,
                REQ_POLL, REQ_PAUSE, REQ_RESUME, REQ_POLL, REQ_DEACTIVATE};
    dir_now = '{32'd0, 32'd999, 32'd1000, 32'd1001, 32'd5500,
                32'd5600, 32'd5700, 32'd6000, 32'd9000, 32'd9100,
                32'd9200, 32'd10200, 32'd10300, 32'd20000, 32'hFFFF_FF00,
                32'h0000_02E7, 32'h0000_02E8, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF,
                32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'd0};
    for (int i = 0; i < 25; i++) send_request(dir_req[i], dir_now[i]);
  endtask

  // One random phase under a fixed register setting. Starts with an
  // activate so the sequence is well formed, then mostly polls; a stopped
  // timer is restarted often so oneshot and turn modes keep firing.
  task automatic run_phase(logic [ModeW-1:0] mode_v, logic [TimeW-1:0] per_v,
                           logic [TurnW-1:0] lim_v, logic act_v);
    logic [TimeW-1:0] now;
    logic [ReqW-1:0]  req;
    int unsigned      pick;
    drain_results();
    write_regs(mode_v, per_v, lim_v, act_v);
    // start some phases just short of the 32-bit wrap
    now = ($urandom_range(2) == 0) ? 32'hFFFF_F000 + $urandom_range(4095) : $urandom;
    send_request(REQ_ACTIVATE, now);
    repeat (PHASE_ITEMS) begin
      now  = next_time(now);
      pick = $urandom_range(99);
      if (pick < 3)
        req = pick[0] ? REQ_BAD_HI : REQ_BAD_LO;
      else if (!tracker.running && pick < 40)
        req = pick[1] ? REQ_ACTIVATE : REQ_RESUME;
      else if (pick < 72)
        req = REQ_POLL;
      else
        req = other_ops[$urandom_range(4)];
      send_request(req, now);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Regime 1: sender rarely idle, receiver stalls most cycles.
    src_idle_pct   = 11;
    sink_stall_pct = 73;
    run_directed();
    run_phase(MODE_REPEAT, 32'd1000, 8'd1, 1'b1);
    run_phase(MODE_ONESHOT, 32'd37, 8'd3, 1'b0);
    run_phase(MODE_TURN, 32'd1, 8'd0, 1'b1);       // limit zero stops at first

    // Regime 2: the other way round.
    src_idle_pct   = 73;
    sink_stall_pct = 11;
    run_phase(MODE_TURN, 32'd250, 8'd255, 1'b0);
    run_phase(MODE_UNUSED, 32'd0, 8'd2, 1'b1);     // unused mode, period zero
    run_phase(MODE_REPEAT, 32'hFFFF_FFFF, 8'd7, 1'b1);

    // Regime 3: full throughput on both sides.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_phase(MODE_TURN, $urandom_range(5000, 1), 8'($urandom_range(255)),
              1'($urandom_range(1)));
    run_phase(MODE_ONESHOT, 32'h8000_0000, 8'($urandom_range(255)), 1'b1);
    run_phase(MODE_REPEAT, $urandom, 8'd1, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("periodic_soft_timer_tb OK");
    end else begin
      $display("periodic_soft_timer_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_rem.sv
rtl/pst_dp.sv
rtl/pst_ctrl.sv
rtl/periodic_soft_timer.sv
tb/sv/periodic_soft_timer_tb.sv
